// ===== hdl/nvfp4_pkg.sv =====
// nvfp4_pkg: shared types, constants and fp32 helper functions for the
// NVFP4 dequantizer. Used by every module in hdl/.
package nvfp4_pkg;

  localparam int unsigned CfgIdxW = 1;

  typedef enum logic [CfgIdxW-1:0] {
    REG_TENSOR_SCALE   = 1'b0,
    REG_SCALES_PRESENT = 1'b1
  } cfg_reg_t;

  localparam logic [31:0] GlobalScaleRst = 32'h3F80_0000;
  localparam logic [31:0] QnanBits       = 32'h7FC0_0000;
  localparam logic [31:0] QuietBit       = 32'h0040_0000;

  // Unpacked float operand: sign, unbiased-ish exponent, 24-bit significand
  typedef struct packed {
    logic              sign;
    logic              zero;
    logic              inf;
    logic              nan;
    logic signed [9:0] exp;   // exponent of significand bit 23
    logic [23:0]       man;   // normalized: bit 23 set unless zero
  } fop_t;

  // Product waiting to be rounded
  typedef struct packed {
    logic              sign;
    logic              zero;
    logic              inf;
    logic              nan;
    logic signed [9:0] exp;   // exponent of bit 47 of prod
    logic [47:0]       prod;
  } fprod_t;

  // Count leading zeros of a 24-bit value
  function automatic logic [4:0] clz24(input logic [23:0] v);
    logic [4:0] n;
    logic       hit;
    n   = 5'd24;
    hit = 1'b0;
    for (int i = 23; i >= 0; i--) begin
      if (!hit && v[i]) begin
        n   = 5'(23 - i);
        hit = 1'b1;
      end
    end
    return n;
  endfunction

  // Unpack fp32 bits, normalizing subnormals
  function automatic fop_t unpack32(input logic [31:0] b);
    fop_t       o;
    logic [4:0] lz;
    logic [23:0] m;
    o.sign = b[31];
    o.nan  = (b[30:23] == 8'hFF) && (b[22:0] != '0);
    o.inf  = (b[30:23] == 8'hFF) && (b[22:0] == '0);
    o.zero = (b[30:0] == '0);
    if (b[30:23] == '0) begin
      m     = {1'b0, b[22:0]};
      lz    = clz24(m);
      o.man = m << lz;
      o.exp = 10'sd1 - 10'sd127 - $signed({5'd0, lz});
    end else begin
      o.man = {1'b1, b[22:0]};
      o.exp = $signed({2'b00, b[30:23]}) - 10'sd127;
    end
    return o;
  endfunction

  // Decode an E4M3 scale byte; 0x7F/0xFF give signed zero
  function automatic fop_t unpack_e4m3(input logic [7:0] b);
    fop_t       o;
    logic [3:0] e;
    logic [2:0] m;
    e = b[6:3];
    m = b[2:0];
    o.sign = b[7];
    o.nan  = 1'b0;
    o.inf  = 1'b0;
    o.zero = ((e == '0) && (m == '0)) || ((e == 4'hF) && (m == 3'h7));
    if (e == '0) begin
      // man * 2^-9
      priority if (m[2]) begin
        o.man = {m, 21'd0};
        o.exp = -10'sd7;
      end else if (m[1]) begin
        o.man = {m[1:0], 22'd0};
        o.exp = -10'sd8;
      end else begin
        o.man = {m[0], 23'd0};
        o.exp = -10'sd9;
      end
    end else begin
      o.man = {1'b1, m, 20'd0};
      o.exp = $signed({6'd0, e}) - 10'sd7;
    end
    return o;
  endfunction

  // Decode an E2M1 code to +-{0,.5,1,1.5,2,3,4,6}
  function automatic fop_t unpack_e2m1(input logic [3:0] c);
    fop_t o;
    o.sign = c[3];
    o.nan  = 1'b0;
    o.inf  = 1'b0;
    o.zero = (c[2:0] == '0);
    unique case (c[2:0])
      3'd0: begin o.man = 24'd0;       o.exp = 10'sd0;  end
      3'd1: begin o.man = 24'h80_0000; o.exp = -10'sd1; end
      3'd2: begin o.man = 24'h80_0000; o.exp = 10'sd0;  end
      3'd3: begin o.man = 24'hC0_0000; o.exp = 10'sd0;  end
      3'd4: begin o.man = 24'h80_0000; o.exp = 10'sd1;  end
      3'd5: begin o.man = 24'hC0_0000; o.exp = 10'sd1;  end
      3'd6: begin o.man = 24'h80_0000; o.exp = 10'sd2;  end
      default: begin o.man = 24'hC0_0000; o.exp = 10'sd2; end
    endcase
    return o;
  endfunction

  // Round a product to fp32, RNE, with subnormals and overflow
  function automatic logic [31:0] round32(input fprod_t p);
    logic [47:0]       pr;
    logic signed [10:0] e;
    logic signed [10:0] be;
    logic [6:0]        sh;
    logic [49:0]       w;
    logic [23:0]       kept;
    logic              g;
    logic              st;
    logic [24:0]       rnd;
    logic [7:0]        ef;
    logic [31:0]       r;
    pr = p.prod;
    e  = 11'(p.exp);
    // prod has top bit at 47 or 46
    if (!pr[47]) begin
      pr = pr << 1;
      e  = e - 11'sd1;
    end
    be = e + 11'sd127;
    if (be >= 11'sd1) begin
      sh = 7'd0;
    end else if (be < -11'sd30) begin
      sh = 7'd31;
    end else begin
      sh = 7'(11'sd1 - be);
    end
    w    = {pr, 2'b00} >> sh;
    st   = ((({pr, 2'b00}) & ~(50'h3_FFFF_FFFF_FFFF << sh)) != '0);
    kept = w[49:26];
    g    = w[25];
    st   = st | (w[24:0] != '0);
    rnd  = {1'b0, kept} + 25'(g & (st | kept[0]));
    if (sh != '0) begin
      // subnormal path; carry into bit 23 makes it the smallest normal
      r = {p.sign, 8'(rnd[23]), rnd[22:0]};
    end else if (rnd[24]) begin
      ef = 8'(be + 11'sd1);
      r  = (be + 11'sd1 >= 11'sd255) ? {p.sign, 8'hFF, 23'd0} : {p.sign, ef, 23'd0};
    end else begin
      ef = 8'(be);
      r  = (be >= 11'sd255) ? {p.sign, 8'hFF, 23'd0} : {p.sign, ef, rnd[22:0]};
    end
    priority if (p.nan) begin
      r = QnanBits;
    end else if (p.inf) begin
      r = {p.sign, 8'hFF, 23'd0};
    end else if (p.zero) begin
      r = {p.sign, 31'd0};
    end
    return r;
  endfunction

  // Sign, class and exponent of a product before multiplying significands
  function automatic fprod_t mul_setup(input fop_t a, input fop_t b);
    fprod_t p;
    p.sign = a.sign ^ b.sign;
    p.nan  = a.nan | b.nan | (a.inf & b.zero) | (a.zero & b.inf);
    p.inf  = a.inf | b.inf;
    p.zero = a.zero | b.zero;
    p.exp  = a.exp + b.exp + 10'sd1;
    p.prod = '0;
    return p;
  endfunction

endpackage

// ===== hdl/nvfp4_mul.sv =====
// nvfp4_mul: pipelined fp32 multiplier stage pair: significand product
// registered, then rounding registered. Depends on nvfp4_pkg.
module nvfp4_mul
  import nvfp4_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        adv,       // pipeline advances this cycle
  input  logic        in_vld,
  input  fop_t        a,
  input  fop_t        b,
  input  logic [3:0]  side_in,   // code travelling alongside
  input  logic        nan_in,
  output logic        out_vld,
  output logic [31:0] res,
  output logic [3:0]  side_out,
  output logic        nan_out
);

  fprod_t     p_r;
  logic       v1_r;
  logic [3:0] side1_r;
  logic       nan1_r;
  logic       v2_r;
  logic [31:0] res_r;
  logic [3:0] side2_r;
  logic       nan2_r;
  fprod_t     p_nxt;

  always_comb begin
    p_nxt      = mul_setup(a, b);
    p_nxt.prod = a.man * b.man;
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_vld;
      v2_r <= v1_r;
    end
  end

  // multiply, then round
  always_ff @(posedge clk) begin
    if (adv) begin
      p_r     <= p_nxt;
      side1_r <= side_in;
      nan1_r  <= nan_in;
      res_r   <= round32(p_r);
      side2_r <= side1_r;
      nan2_r  <= nan1_r;
    end
  end

  assign out_vld  = v2_r;
  assign res      = res_r;
  assign side_out = side2_r;
  assign nan_out  = nan2_r;

endmodule

// ===== hdl/nvfp4_dequantizer.sv =====
// nvfp4_dequantizer: top level. Decode stage, two fp32 multipliers of two
// stages each, output register. Depends on nvfp4_pkg and nvfp4_mul.
// Throughput: one beat per cycle; the pipeline holds while an output beat
// is stalled. Reset (rst_n low, synchronous): valid bits cleared,
// tensor scale = 1.0, scales_present = 1.
module nvfp4_dequantizer
  import nvfp4_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CfgIdxW-1:0]   cfg_index,
  input  logic [31:0]          cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [3:0]           in_code,
  input  logic [7:0]           in_scale_code,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [31:0]          out_value
);

  logic [31:0] gscale_r;
  logic        present_r;
  logic        adv;
  logic        d_vld_r;
  fop_t        d_g_r;
  fop_t        d_s_r;
  logic [3:0]  d_code_r;
  logic        d_nan_r;
  logic        m1_vld;
  logic [31:0] m1_res;
  logic [3:0]  m1_code;
  logic        m1_nan;
  logic        m2_vld;
  logic [31:0] m2_res;
  logic [3:0]  m2_side;
  logic        m2_nan;
  logic        o_vld_r;
  logic [31:0] o_val_r;
  logic [31:0] o_val_nxt;
  fop_t        one_op;

  // whole pipe holds while the output beat is stalled
  assign adv      = !(o_vld_r && out_stall);
  assign in_stall = !adv;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gscale_r  <= GlobalScaleRst;
      present_r <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_TENSOR_SCALE:   gscale_r  <= cfg_data;
        REG_SCALES_PRESENT: present_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    one_op      = '0;
    one_op.man  = 24'h80_0000;
  end

  // decode stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_vld_r <= 1'b0;
    end else if (adv) begin
      d_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_g_r    <= unpack32(gscale_r);
      d_s_r    <= present_r ? unpack_e4m3(in_scale_code) : one_op;
      d_code_r <= in_code;
      d_nan_r  <= (gscale_r[30:23] == 8'hFF) && (gscale_r[22:0] != '0);
    end
  end

  // global scale times group scale
  nvfp4_mul u_mul_scale (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_vld   (d_vld_r),
    .a        (d_g_r),
    .b        (d_s_r),
    .side_in  (d_code_r),
    .nan_in   (d_nan_r),
    .out_vld  (m1_vld),
    .res      (m1_res),
    .side_out (m1_code),
    .nan_out  (m1_nan)
  );

  // code value times combined scale
  nvfp4_mul u_mul_code (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_vld   (m1_vld),
    .a        (unpack_e2m1(m1_code)),
    .b        (unpack32(m1_res)),
    .side_in  (m1_code),
    .nan_in   (m1_nan),
    .out_vld  (m2_vld),
    .res      (m2_res),
    .side_out (m2_side),
    .nan_out  (m2_nan)
  );

  // NaN global scale passes through quieted; the user must keep config stable while busy, the block does not enforce it
  assign o_val_nxt = m2_nan ? (gscale_r | QuietBit) : m2_res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_vld_r <= 1'b0;
    end else if (adv) begin
      o_vld_r <= m2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      o_val_r <= (m2_side[3] & 1'b0) ? '0 : o_val_nxt;
    end
  end

  assign out_valid = o_vld_r;
  assign out_value = o_val_r;

endmodule
